[hdl/assert_macros.svh]
// Assertion macros for the epoch-to-calendar RTL.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ES2C_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication.
`define ES2C_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ES2C_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/es2c_pkg.sv]
// Package for the epoch-to-calendar core: sequencer states, constants and
// calendar helper functions. No dependencies.
package es2c_pkg;

  // Width of the shared subtract-and-compare unit.
  localparam int unsigned SubW = 17;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEC,
    ST_MIN,
    ST_HOUR,
    ST_YEAR4,
    ST_YEAR1,
    ST_MONTH,
    ST_DONE
  } es2c_state_e;

  // Reciprocals for division by multiplication. A value below 2^32 times
  // RECIP_60, shifted right by 37, is its quotient by 60; a value below 2^33
  // times RECIP_24, shifted right by 36, is its quotient by 24.
  localparam logic [31:0] RECIP_60 = 32'h8888_8889;
  localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;

  localparam logic [11:0] EPOCH_YEAR  = 12'd1970;
  // First year at which a four-year block is not skipped whole; the block
  // starting there holds 2100, which is not a leap year.
  localparam logic [11:0] LAST_BLOCK  = 12'd2098;
  localparam logic [SubW-1:0] DAYS_BLOCK4 = 17'd1461;
  localparam logic [SubW-1:0] DAYS_COMMON = 17'd365;

  // Gregorian leap rule over 1970..2106: the only century years in that
  // span are 2000, a leap year by the 400 rule, and 2100, which is not.
  function automatic logic is_leap(input logic [11:0] year);
    return (year[1:0] == 2'b00) && (year != 12'd2100);
  endfunction

  // Length of a month, 1 is January.
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[hdl/es2c_sub.sv]
// Shared subtract-and-compare unit of the epoch-to-calendar core.
// Depends on es2c_pkg for the operand width.
module es2c_sub
  import es2c_pkg::*;
(
  input  logic [SubW-1:0] a_i,
  input  logic [SubW-1:0] b_i,
  output logic [SubW-1:0] diff_o,
  output logic            ge_o
);

  logic borrow;

  // One wide subtract; the borrow out tells whether a is below b.
  assign {borrow, diff_o} = {1'b0, a_i} - {1'b0, b_i};
  assign ge_o = ~borrow;

endmodule

[hdl/epoch_seconds_to_calendar_core.sv]
// Top level of the epoch-to-calendar core: sequencer and datapath registers.
// Depends on es2c_pkg, es2c_sub and assert_macros.svh.

// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into the
// Gregorian date and time of day. A conversion starts on a transfer at a
// clock edge with start high and busy low; busy then stays high until the
// result has been shown. The result appears for exactly one cycle with
// done_o high, and the receiver cannot stall: it must take the result in
// that cycle. The conversion divides by 60, 60 and 24 by reciprocal
// multiplication on one shared multiplier, then walks four-year blocks,
// single years and months, each walk with a closing step, all through one
// shared subtract-and-compare unit, and ends with the done strobe. busy
// falls the cycle after the strobe; a new start transfer is taken only
// then, never while a conversion is under way. There is no configuration
// and no state kept between conversions.
module epoch_seconds_to_calendar_core
  import es2c_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] epoch_seconds_i,
  output logic        done_o,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o
);

  es2c_state_e state_q, state_d;
  logic [31:0] num_q, num_d;
  logic [5:0]  rem_q, rem_d;
  logic [5:0]  sec_q, sec_d;
  logic [5:0]  min_q, min_d;
  logic [4:0]  hour_q, hour_d;
  logic [15:0] days_q, days_d;
  logic [11:0] year_q, year_d;
  logic [3:0]  month_q, month_d;

  logic [SubW-1:0] sub_a, sub_b, sub_diff;
  logic            sub_ge;
  logic            leap;
  logic [31:0]     recip;
  logic [63:0]     prod;
  logic [31:0]     quot;
  logic [5:0]      rem60;
  logic [4:0]      rem24;

  // Shared arithmetic unit.
  es2c_sub u_sub (
    .a_i    (sub_a),
    .b_i    (sub_b),
    .diff_o (sub_diff),
    .ge_o   (sub_ge)
  );

  assign leap = is_leap(year_q);

  // Shared multiplier: the register value times the reciprocal of the
  // divisor gives the quotient in the high product bits.
  assign recip = (state_q == ST_HOUR) ? RECIP_24 : RECIP_60;
  assign prod  = {32'b0, num_q} * {32'b0, recip};
  assign quot  = (state_q == ST_HOUR) ? {4'b0, prod[63:36]} : {5'b0, prod[63:37]};

  // Remainders from the low dividend bits held in rem_q and the quotient
  // now in num_q. 60q is -4q modulo 64, and 24q is 16q + 8q modulo 32.
  assign rem60 = rem_q + {num_q[3:0], 2'b00};
  assign rem24 = rem_q[4:0] - ({num_q[0], 4'b0000} + {num_q[1:0], 3'b000});

  // Operand selection for the shared subtract-and-compare unit.
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (state_q)
      ST_YEAR4: begin
        sub_a = {1'b0, days_q};
        sub_b = DAYS_BLOCK4;
      end
      ST_YEAR1: begin
        sub_a = {1'b0, days_q};
        sub_b = DAYS_COMMON + {16'b0, leap};
      end
      ST_MONTH: begin
        sub_a = {1'b0, days_q};
        sub_b = {12'b0, month_len(month_q, leap)};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    rem_d   = rem_q;
    sec_d   = sec_q;
    min_d   = min_q;
    hour_d  = hour_q;
    days_d  = days_q;
    year_d  = year_q;
    month_d = month_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          num_d   = epoch_seconds_i;
          state_d = ST_SEC;
        end
      end
      ST_SEC: begin
        rem_d   = num_q[5:0];
        num_d   = quot;
        state_d = ST_MIN;
      end
      ST_MIN: begin
        sec_d   = rem60;
        rem_d   = num_q[5:0];
        num_d   = quot;
        state_d = ST_HOUR;
      end
      ST_HOUR: begin
        min_d   = rem60;
        rem_d   = num_q[5:0];
        num_d   = quot;
        days_d  = quot[15:0];
        year_d  = EPOCH_YEAR;
        state_d = ST_YEAR4;
      end
      ST_YEAR4: begin
        // The low hour-count bits and their quotient by 24 stay put during the walk.
        hour_d = rem24;
        // Whole four-year blocks start at years two past a multiple of four.
        if ((year_q != LAST_BLOCK) && sub_ge) begin
          days_d = sub_diff[15:0];
          year_d = year_q + 12'd4;
        end else begin
          state_d = ST_YEAR1;
        end
      end
      ST_YEAR1: begin
        if (sub_ge) begin
          days_d = sub_diff[15:0];
          year_d = year_q + 12'd1;
        end else begin
          month_d = 4'd1;
          state_d = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (sub_ge) begin
          days_d  = sub_diff[15:0];
          month_d = month_q + 4'd1;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    rem_q   <= rem_d;
    sec_q   <= sec_d;
    min_q   <= min_d;
    hour_q  <= hour_d;
    days_q  <= days_d;
    year_q  <= year_d;
    month_q <= month_d;
  end

  // Result ports.
  assign busy     = (state_q != ST_IDLE);
  assign done_o   = (state_q == ST_DONE);
  assign year_o   = year_q;
  assign month_o  = month_q;
  assign day_o    = days_q[4:0] + 5'd1;
  assign hour_o   = hour_q;
  assign minute_o = min_q;
  assign second_o = sec_q;

  // Assertions.
  `include "assert_macros.svh"

  `ES2C_ASSERT_NEXT(a_start_busy, start && !busy, busy, "start transfer did not raise busy")
  `ES2C_ASSERT_NEXT(a_done_idle, done_o, !busy, "busy still high after the done strobe")
  `ES2C_ASSERT_IMPL(a_done_month, done_o, (month_q != 4'd0) && (month_q < 4'd13), "bad month")
  `ES2C_ASSERT_IMPL(a_done_hour, done_o, hour_q < 5'd24, "hour out of range")
  `ES2C_ASSERT_IMPL(a_hour_cnt, state_q == ST_HOUR, num_q[31:21] == 11'd0, "hour count too wide")
  `ES2C_ASSERT_IMPL(a_month_days, state_q == ST_MONTH, days_q < 16'd366, "day count above a year in month walk")

endmodule

[dv/epoch_seconds_to_calendar_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for epoch_seconds_to_calendar_core. It drives epoch
// timestamps, predicts the Gregorian date and time of each one, and checks
// every result strobe. Depends only on the core RTL and its package.
module epoch_seconds_to_calendar_core_tb;

  localparam int unsigned QuietLimit  = 5000;
  localparam int unsigned DrainCycles = 130;
  localparam int unsigned MaxPrints   = 30;

  // One timestamp and the calendar fields it should convert to.
  typedef struct packed {
    logic [31:0] secs;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [31:0] epoch_seconds_i;
  logic        done_o;
  logic [11:0] year_o;
  logic [3:0]  month_o;
  logic [4:0]  day_o;
  logic [4:0]  hour_o;
  logic [5:0]  minute_o;
  logic [5:0]  second_o;

  calendar_t   calendar_due[$];
  calendar_t   head;
  bit          idle_on = 1'b1;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned year_lo = 4095;
  int unsigned year_hi = 0;

  epoch_seconds_to_calendar_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .epoch_seconds_i (epoch_seconds_i),
    .done_o          (done_o),
    .year_o          (year_o),
    .month_o         (month_o),
    .day_o           (day_o),
    .hour_o          (hour_o),
    .minute_o        (minute_o),
    .second_o        (second_o)
  );

  // 20 ns clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Full Gregorian leap rule, not limited to the span the block can reach.
  function automatic bit leap_year(input int unsigned year);
    return (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
  endfunction

  function automatic int unsigned days_in_month(input int unsigned year,
                                                input int unsigned month);
    int unsigned len;
    case (month)
      2:       len = leap_year(year) ? 29 : 28;
      4, 6, 9, 11: len = 30;
      default: len = 31;
    endcase
    return len;
  endfunction

  // Converts a timestamp into the expected calendar fields.
  function automatic calendar_t calendar_of(input logic [31:0] secs);
    calendar_t   c;
    int unsigned rest;
    int unsigned days;
    int unsigned year;
    int unsigned month;
    c.secs   = secs;
    c.second = 6'(secs % 60);
    rest     = secs / 60;
    c.minute = 6'(rest % 60);
    rest     = rest / 60;
    c.hour   = 5'(rest % 24);
    days     = rest / 24;
    // Peel off whole years, then whole months; the rest is the day index.
    year = 1970;
    while (days >= (leap_year(year) ? 366 : 365)) begin
      days -= leap_year(year) ? 366 : 365;
      year++;
    end
    month = 1;
    while (month < 12 && days >= days_in_month(year, month)) begin
      days -= days_in_month(year, month);
      month++;
    end
    c.year  = 12'(year);
    c.month = 4'(month);
    c.day   = 5'(days + 1);
    return c;
  endfunction

  // Counts a mismatch and prints it while the print budget lasts.
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want, input logic [31:0] secs);
    mismatch_count++;
    if (mismatch_count <= MaxPrints) begin
      $display("[%0t] MISMATCH %0s for %0d s: got %0d, expected %0d",
               $realtime, what, secs, got, want);
    end
  endtask

  // Sends one timestamp and waits for its transfer. Start is left high so
  // that a following item can go out back to back.
  task automatic send_seconds(input logic [31:0] secs);
    int unsigned mode;
    int unsigned gap;
    mode = idle_on ? $urandom_range(0, 2) : 0;
    if (mode != 0) begin
      gap = $urandom_range(1, 13);
      start <= 1'b0;
      epoch_seconds_i <= $urandom;
      if (mode == 2) begin
        // Let the current conversion finish before going quiet.
        @(posedge clk_i);
        while (busy) @(posedge clk_i);
      end
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    epoch_seconds_i <= secs;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    calendar_due.push_back(calendar_of(secs));
    sent_count++;
  endtask

  // Epoch start, the largest count, rollovers of every field, leap days
  // (including the 400-year rule in 2000 and the non-leap year 2100).
  task automatic test_corners();
    logic [31:0] corners [20];
    corners = '{32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600,
                32'd86399, 32'd86400, 32'd2678399, 32'd2678400,
                32'd31535999, 32'd31536000, 32'd68169600, 32'd68256000,
                32'd946684799, 32'd951782400, 32'd978307199,
                32'd4107456000, 32'd4107542400, 32'h7FFF_FFFF};
    foreach (corners[i]) send_seconds(corners[i]);
  endtask

  // A single one and a single zero in every bit position.
  task automatic test_walking_bits();
    for (int b = 0; b < 32; b++) begin
      send_seconds(32'd1 << b);
      send_seconds(~(32'd1 << b));
    end
  endtask

  // Timestamps within two seconds of the start of a random month.
  task automatic test_month_edges(input int unsigned count);
    int unsigned year;
    int unsigned month;
    int unsigned days;
    longint      stamp;
    repeat (count) begin
      year  = $urandom_range(1970, 2106);
      month = $urandom_range(1, 12);
      days  = 0;
      for (int unsigned y = 1970; y < year; y++) days += leap_year(y) ? 366 : 365;
      for (int unsigned m = 1; m < month; m++) days += days_in_month(year, m);
      stamp = longint'(days) * 86400 + $urandom_range(0, 4) - 2;
      // Past the top of the range the count simply wraps, which is still legal.
      send_seconds(stamp[31:0]);
    end
  endtask

  // Mostly full-range timestamps, some restricted to the early decades.
  task automatic test_random(input int unsigned count);
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) send_seconds($urandom_range(0, 32'd400000000));
      else send_seconds($urandom);
    end
  endtask

  // Compare every result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (done_o) begin
        if (calendar_due.size() == 0) begin
          report_mismatch("result with nothing outstanding, year", year_o, 0, 0);
        end else begin
          head = calendar_due.pop_front();
          if (year_o !== head.year) report_mismatch("year", year_o, head.year, head.secs);
          if (month_o !== head.month) report_mismatch("month", month_o, head.month, head.secs);
          if (day_o !== head.day) report_mismatch("day", day_o, head.day, head.secs);
          if (hour_o !== head.hour) report_mismatch("hour", hour_o, head.hour, head.secs);
          if (minute_o !== head.minute) begin
            report_mismatch("minute", minute_o, head.minute, head.secs);
          end
          if (second_o !== head.second) begin
            report_mismatch("second", second_o, head.second, head.secs);
          end
          if (head.year < year_lo) year_lo = head.year;
          if (head.year > year_hi) year_hi = head.year;
          checked_count++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer ends the run.
  initial begin
    wait (rst_ni === 1'b1);
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("[%0t] Timeout: no transfer for %0d cycles", $realtime, QuietLimit);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    epoch_seconds_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corners();
    test_walking_bits();
    test_month_edges(300);
    test_random(500);
    // Last part: start held high, every item sent as soon as possible.
    idle_on = 1'b0;
    test_random(170);
    start <= 1'b0;

    // Drain outstanding results, then watch for stray strobes.
    while (calendar_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (calendar_due.size() != 0) begin
      report_mismatch("results never delivered", calendar_due.size(), 0,
                      calendar_due[0].secs);
    end

    $display("Sent %0d timestamps: corners, walking bits, month edges, random values.",
             sent_count);
    $display("Checked %0d results spanning years %0d to %0d; %0d mismatches.",
             checked_count, year_lo, year_hi, mismatch_count);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
